/* rtl/omfr_pkg.sv */
// ----------------------------------------------------------------------------
// omfr_pkg: shared types and constants of the marker frame receiver
// Holds register reset values, configuration register indexes, event codes
// and the structs of the slicer's decisions and the framer's results.
// ----------------------------------------------------------------------------
package omfr_pkg;

    // Default frame geometry.
    localparam int PAYLOAD_BITS_DEF = 8;
    localparam int MARKER_BITS_DEF  = 8;

    // Configuration register widths and reset values.
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_W-1:0] SPB_RESET          = 8'd100;
    localparam logic [CFG_W-1:0] HUNT_THR_RESET     = 8'd90;
    localparam logic [CFG_W-1:0] FRAME_THR_RESET    = 8'd70;
    localparam logic [CFG_W-1:0] START_MARKER_RESET = 8'hFF;
    localparam logic [CFG_W-1:0] END_MARKER_RESET   = 8'h01;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_BIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HUNT_THRESHOLD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER      = 3'd4;

    // Event codes reported with each decided bit.
    localparam int EVENT_W = 3;
    localparam logic [EVENT_W-1:0] EV_BIT      = 3'd0;
    localparam logic [EVENT_W-1:0] EV_START    = 3'd1;
    localparam logic [EVENT_W-1:0] EV_PAYLOAD  = 3'd2;
    localparam logic [EVENT_W-1:0] EV_END_GOOD = 3'd3;
    localparam logic [EVENT_W-1:0] EV_END_BAD  = 3'd4;

    localparam int PAYLOAD_OUT_W = 8;

    // Bit decision from the slicer.
    typedef struct packed {
        logic valid;
        logic bit_val;
    } decision_t;

    // One result item from the framer.
    typedef struct packed {
        logic                     valid;
        logic                     decided_bit;
        logic [EVENT_W-1:0]       event_res;
        logic [PAYLOAD_OUT_W-1:0] payload;
        logic                     parity_ok;
    } result_t;

endpackage

/* rtl/omfr_slicer.sv */
// ----------------------------------------------------------------------------
// omfr_slicer: oversampled bit slicer
// Counts sample ticks and ones over one bit period and decides a bit against
// the threshold that the framer's current phase selects.
// ----------------------------------------------------------------------------
module omfr_slicer (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     step_en,
    input  logic                     level,
    input  logic [omfr_pkg::CFG_W-1:0] samples_per_bit,
    input  logic [omfr_pkg::CFG_W-1:0] hunt_threshold,
    input  logic [omfr_pkg::CFG_W-1:0] frame_threshold,
    input  logic                     hunting,
    output omfr_pkg::decision_t      decision
);
    import omfr_pkg::*;

    logic [CFG_W-1:0] sample_count_reg, sample_count_next;
    logic [CFG_W-1:0] ones_count_reg, ones_count_next;
    logic [CFG_W-1:0] sample_inc;
    logic [CFG_W-1:0] ones_inc;
    logic [CFG_W-1:0] threshold;

    // Count this sample; the ones count saturates at its top value.
    always_comb begin
        sample_inc = sample_count_reg + CFG_W'(1);
        ones_inc   = (level && (ones_count_reg != {CFG_W{1'b1}})) ?
                     ones_count_reg + CFG_W'(1) : ones_count_reg;
        threshold  = hunting ? hunt_threshold : frame_threshold;

        decision.valid   = (sample_inc == samples_per_bit);
        decision.bit_val = (ones_inc >= threshold);

        if (decision.valid) begin
            sample_count_next = '0;
            ones_count_next   = '0;
        end else begin
            sample_count_next = sample_inc;
            ones_count_next   = ones_inc;
        end
    end

    // Counters advance once per processed sample.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= '0;
            ones_count_reg   <= '0;
        end else if (step_en) begin
            sample_count_reg <= sample_count_next;
            ones_count_reg   <= ones_count_next;
        end
    end

endmodule

/* rtl/omfr_framer.sv */
// ----------------------------------------------------------------------------
// omfr_framer: marker framing of decided bits
// Shifts decided bits in, hunts for the start marker, collects payload and
// parity, then checks the end marker. Reports one result per decided bit.
// ----------------------------------------------------------------------------
module omfr_framer #(
    parameter int PAYLOAD_BITS = omfr_pkg::PAYLOAD_BITS_DEF,
    parameter int MARKER_BITS  = omfr_pkg::MARKER_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step_en,
    input  omfr_pkg::decision_t        decision,
    input  logic [omfr_pkg::CFG_W-1:0] start_marker,
    input  logic [omfr_pkg::CFG_W-1:0] end_marker,
    output logic                       hunting,
    output omfr_pkg::result_t          result
);
    import omfr_pkg::*;

    localparam int SHIFT_BITS = (PAYLOAD_BITS + 1 > MARKER_BITS) ?
                                (PAYLOAD_BITS + 1) : MARKER_BITS;
    localparam int IDX_W      = $clog2(SHIFT_BITS + 1);
    localparam int EXT_W      = SHIFT_BITS + CFG_W + PAYLOAD_OUT_W;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_END     = 3'b100
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [SHIFT_BITS-1:0]  bit_shift_reg, bit_shift_next;
    logic [IDX_W-1:0]       bit_index_reg, bit_index_next;
    logic [SHIFT_BITS-1:0]  shifted;
    logic [IDX_W-1:0]       index_inc;
    logic [EXT_W-1:0]       start_ext;
    logic [EXT_W-1:0]       end_ext;
    logic [SHIFT_BITS-1:0]  start_mask;
    logic [MARKER_BITS-1:0] end_pattern;
    logic [PAYLOAD_BITS-1:0] data_bits;
    logic [EXT_W-1:0]       data_ext;

    // Markers are zero-extended, or cut, to the marker length.
    always_comb begin
        start_ext  = EXT_W'(start_marker);
        end_ext    = EXT_W'(end_marker);
        start_mask = '0;
        for (int i = 0; i < MARKER_BITS; i++) begin
            start_mask[i] = start_ext[i];
        end
        end_pattern = end_ext[MARKER_BITS-1:0];
    end

    // Phase and shift register update for one decided bit.
    always_comb begin
        shifted    = {bit_shift_reg[SHIFT_BITS-2:0], decision.bit_val};
        index_inc  = bit_index_reg + IDX_W'(1);
        data_bits  = shifted[PAYLOAD_BITS:1];
        data_ext   = EXT_W'(data_bits);
        hunting    = (phase_reg != PH_PAYLOAD) && (phase_reg != PH_END);

        phase_next     = phase_reg;
        bit_shift_next = bit_shift_reg;
        bit_index_next = bit_index_reg;

        result.valid       = decision.valid;
        result.decided_bit = decision.bit_val;
        result.event_res   = EV_BIT;
        result.payload     = '0;
        result.parity_ok   = 1'b0;

        if (decision.valid) begin
            bit_shift_next = shifted;
            unique case (phase_reg)
                PH_PAYLOAD: begin
                    bit_index_next = index_inc;
                    if (index_inc >= IDX_W'(PAYLOAD_BITS + 1)) begin
                        result.event_res = EV_PAYLOAD;
                        result.payload   = data_ext[PAYLOAD_OUT_W-1:0];
                        result.parity_ok = ((^data_bits) == shifted[0]);
                        bit_shift_next   = '0;
                        bit_index_next   = '0;
                        phase_next       = PH_END;
                    end
                end
                PH_END: begin
                    bit_index_next = index_inc;
                    if (index_inc >= IDX_W'(MARKER_BITS)) begin
                        result.event_res = (shifted[MARKER_BITS-1:0] == end_pattern) ?
                                           EV_END_GOOD : EV_END_BAD;
                        bit_index_next   = '0;
                        phase_next       = PH_HUNT;
                    end
                end
                default: begin
                    // Hunting: look for the start marker under its own mask.
                    if ((shifted & start_mask) == start_mask) begin
                        result.event_res = EV_START;
                        bit_shift_next   = '0;
                        bit_index_next   = '0;
                        phase_next       = PH_PAYLOAD;
                    end
                end
            endcase
        end
    end

    // Framing state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT;
            bit_shift_reg <= '0;
            bit_index_reg <= '0;
        end else if (step_en) begin
            phase_reg     <= phase_next;
            bit_shift_reg <= bit_shift_next;
            bit_index_reg <= bit_index_next;
        end
    end

endmodule

/* rtl/oversampled_marker_frame_receiver_core.sv */
// ----------------------------------------------------------------------------
// oversampled_marker_frame_receiver_core: oversampled marker frame receiver
// Slices comparator samples into bits and frames them between a start marker
// and an end marker, with an even-parity payload in between.
//
// Usage:
//   s_ channel: one comparator sample per item, level in s_tdata[0].
//   m_ channel: one item per decided bit; tdata carries the bit, the payload
//   and the parity flag, tuser the event code.
//   cfg channel: register writes by index, always ready; write only while
//   the block is idle.
// Flow: one sample item is accepted every cycle while the result register
//   is free. A sample is held in the input register, then the slicer and
//   framer logic updates the state and loads the result register with the
//   result item of the sample that closes its bit period.
// Reset: aresetn clears the counters, the shift register and the phase to
//   hunting, and loads the register defaults.
// Stall: while m_tready is low and a result is held, the full input
//   register keeps its sample and s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module oversampled_marker_frame_receiver_core #(
    parameter int PAYLOAD_BITS = omfr_pkg::PAYLOAD_BITS_DEF,
    parameter int MARKER_BITS  = omfr_pkg::MARKER_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Sample input.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [0] level
    // Result output.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,   // [0] decided_bit, [8:1] payload,
                                                      // [9] parity_ok
    output logic [omfr_pkg::EVENT_W-1:0]   m_tuser,   // [2:0] event_res
    // Configuration writes.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [omfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [omfr_pkg::CFG_W-1:0]     cfg_data
);
    import omfr_pkg::*;

    logic             s1_valid_reg;
    logic             s1_level_reg;
    logic             m_valid_reg;
    logic             m_bit_reg;
    logic [PAYLOAD_OUT_W-1:0] m_payload_reg;
    logic             m_parity_reg;
    logic [EVENT_W-1:0] m_event_reg;

    logic [CFG_W-1:0] spb_reg;
    logic [CFG_W-1:0] hunt_thr_reg;
    logic [CFG_W-1:0] frame_thr_reg;
    logic [CFG_W-1:0] start_marker_reg;
    logic [CFG_W-1:0] end_marker_reg;

    logic      out_free;
    logic      step_en;
    logic      hunting;
    decision_t decision;
    result_t   result;

    // Handshake: the result register frees when empty or being taken.
    assign out_free  = !m_valid_reg || m_tready;
    assign step_en   = s1_valid_reg && out_free;
    assign s_tready  = !s1_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spb_reg          <= SPB_RESET;
            hunt_thr_reg     <= HUNT_THR_RESET;
            frame_thr_reg    <= FRAME_THR_RESET;
            start_marker_reg <= START_MARKER_RESET;
            end_marker_reg   <= END_MARKER_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SAMPLES_PER_BIT: spb_reg          <= cfg_data;
                CFG_HUNT_THRESHOLD:  hunt_thr_reg     <= cfg_data;
                CFG_FRAME_THRESHOLD: frame_thr_reg    <= cfg_data;
                CFG_START_MARKER:    start_marker_reg <= cfg_data;
                CFG_END_MARKER:      end_marker_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            s1_level_reg <= s_tdata[0];
        end
    end

    omfr_slicer u_slicer (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step_en         (step_en),
        .level           (s1_level_reg),
        .samples_per_bit (spb_reg),
        .hunt_threshold  (hunt_thr_reg),
        .frame_threshold (frame_thr_reg),
        .hunting         (hunting),
        .decision        (decision)
    );

    omfr_framer #(
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .MARKER_BITS  (MARKER_BITS)
    ) u_framer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (step_en),
        .decision     (decision),
        .start_marker (start_marker_reg),
        .end_marker   (end_marker_reg),
        .hunting      (hunting),
        .result       (result)
    );

    // Result register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= step_en && result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_bit_reg     <= result.decided_bit;
            m_payload_reg <= result.payload;
            m_parity_reg  <= result.parity_ok;
            m_event_reg   <= result.event_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_parity_reg, m_payload_reg, m_bit_reg};
    assign m_tuser  = m_event_reg;

endmodule
